/* sv/cowbm_pkg.sv */
// Package for the copy-on-write block map: field widths, action codes and
// the per-cluster map word layout.
// No dependencies; imported by the top level.
`default_nettype none

package cowbm_pkg;

   // Request and result field widths.
   localparam int ADDR_W  = 28;
   localparam int SIZE_W  = 16;
   localparam int ACT_W   = 3;
   localparam int SLOT_W  = 17;
   localparam int UCL_W   = 13;
   localparam int WCNT_W  = 32;

   // Address geometry: 64 KiB clusters of sixteen 4 KiB sub-blocks.
   localparam int CLUSTER_BYTES = 65536;
   localparam int BLOCK_BYTES   = 4096;
   localparam int SUBS          = 16;
   localparam int SUB_LSB       = $clog2(BLOCK_BYTES);
   localparam int SUB_W         = $clog2(SUBS);
   localparam int CLF_W         = ADDR_W - $clog2(CLUSTER_BYTES);
   localparam int CLUSTER_SPAN  = 2 ** CLF_W;

   localparam logic [SIZE_W-1:0] SIZE_OK = SIZE_W'(BLOCK_BYTES);

   // Request type codes.
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Result action codes.
   localparam logic [ACT_W-1:0] ACT_DIRTY_HIT   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE_ALLOC = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ_FILL   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ_CACHED = 3'd3;
   localparam logic [ACT_W-1:0] ACT_BAD         = 3'd4;

   // Per-cluster map word: dirty and slot-assigned bits for each sub-block.
   typedef struct packed {
      logic [SUBS-1:0] dirty;
      logic [SUBS-1:0] assigned;
   } map_word_type;

endpackage

`default_nettype wire

/* sv/cowbm_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies; used by the top level for the cluster maps and slot table.
`default_nettype none

module cowbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/copy_on_write_block_map.sv */
// Copy-on-write block map top level: request decode, map read-modify-write,
// slot allocation and counters. Depends on cowbm_pkg and cowbm_ram.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_type, req_address, req_size
//   rsp_      out        rsp_valid/rsp_stall  rsp_action, rsp_log_slot,
//                                             rsp_first_cluster_write,
//                                             rsp_unique_clusters, rsp_write_count
//
// A request first reads the cluster map and slot memories, then in its decide
// cycle decides, writes back and loads the result register. The next request
// is taken only after the write back, so one request is in flight at a time.
// After reset a clearing pass writes zero to every map word, one per cycle;
// requests stall until it ends.
// A stalled result holds the block in its decide cycle until it can load.
`default_nettype none

module copy_on_write_block_map
   import cowbm_pkg::*;
#(
   parameter int NUM_CLUSTERS = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_type,
   input  wire logic [ADDR_W-1:0] req_address,
   input  wire logic [SIZE_W-1:0] req_size,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [ACT_W-1:0]  rsp_action,
   output logic      [SLOT_W-1:0] rsp_log_slot,
   output logic                   rsp_first_cluster_write,
   output logic      [UCL_W-1:0]  rsp_unique_clusters,
   output logic      [WCNT_W-1:0] rsp_write_count
);

   // Only clusters reachable by the address field need storage.
   localparam int MAP_DEPTH = (NUM_CLUSTERS < CLUSTER_SPAN) ? NUM_CLUSTERS : CLUSTER_SPAN;
   localparam int CL_W      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int IDX_W     = CL_W + SUB_W;
   localparam int MAP_W     = $bits(map_word_type);

   localparam logic [SLOT_W-1:0] SLOT_MAX = '1;
   localparam logic [UCL_W-1:0]  UCL_MAX  = '1;
   localparam logic [WCNT_W-1:0] WCNT_MAX = '1;
   localparam logic [SUBS-1:0]   SUB_ONE  = SUBS'(1);

   // Control state.
   logic             busy_ff, busy_in;
   logic             clear_ff;
   logic [CL_W-1:0]  clr_idx_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   // Request context held through the decide cycle.
   logic             is_write_ff;
   logic             bad_ff;
   logic [CL_W-1:0]  clu_ff;
   logic [SUB_W-1:0] sub_ff;

   // Running totals.
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic [UCL_W-1:0]  clusters_ff, clusters_in;
   logic [WCNT_W-1:0] writes_ff, writes_in;

   // Result register.
   logic [ACT_W-1:0]  act_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              first_ff;

   logic              req_accept;
   logic              done;
   logic [CLF_W-1:0]  req_cluster;
   logic [SUB_W-1:0]  req_sub;
   logic              req_bad;

   map_word_type      map_rd;
   map_word_type      map_new;
   logic [MAP_W-1:0]  map_rd_bits;
   logic              map_we;
   logic [CL_W-1:0]   map_wa;
   logic [MAP_W-1:0]  map_wd;
   logic              map_upd;

   logic [SLOT_W-1:0] slot_rd;
   logic              slot_we;

   logic [SUBS-1:0]   sub_bit;
   logic [ACT_W-1:0]  act_in;
   logic [SLOT_W-1:0] slot_in;
   logic              first_in;
   logic              take_slot;
   logic              count_write;
   logic              count_cluster;

   // Handshake.
   assign req_stall  = clear_ff | busy_ff;
   assign req_accept = req_valid & ~req_stall;
   assign done       = busy_ff & (~rsp_valid_ff | ~rsp_stall);

   // Address split and request check.
   assign req_cluster = req_address[ADDR_W-1 -: CLF_W];
   assign req_sub     = req_address[SUB_LSB +: SUB_W];
   assign req_bad     = (req_size != SIZE_OK) || (32'(req_cluster) >= NUM_CLUSTERS);

   // Cluster map memory: dirty and assigned bits per cluster.
   assign map_we = clear_ff | (done & map_upd);
   assign map_wa = clear_ff ? clr_idx_ff : clu_ff;
   assign map_wd = clear_ff ? '0 : map_new;
   assign map_rd = map_word_type'(map_rd_bits);

   cowbm_ram #(
      .WIDTH (MAP_W),
      .DEPTH (2 ** CL_W)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_en   (req_accept),
      .rd_addr (req_cluster[CL_W-1:0]),
      .rd_data (map_rd_bits)
   );

   // Log slot table, one entry per sub-block.
   assign slot_we = done & take_slot;

   cowbm_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (2 ** IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr ({clu_ff, sub_ff}),
      .wr_data (next_slot_ff),
      .rd_en   (req_accept),
      .rd_addr ({req_cluster[CL_W-1:0], req_sub}),
      .rd_data (slot_rd)
   );

   // Decide the action from the map word read for this request.
   assign sub_bit = SUB_ONE << sub_ff;

   always_comb begin
      map_new       = map_rd;
      map_upd       = 1'b0;
      act_in        = ACT_BAD;
      slot_in       = '0;
      first_in      = 1'b0;
      take_slot     = 1'b0;
      count_write   = 1'b0;
      count_cluster = 1'b0;
      if (!bad_ff) begin
         if ((map_rd.dirty & sub_bit) != '0) begin
            slot_in = slot_rd;
            if (is_write_ff == REQ_WRITE) begin
               count_write = 1'b1;
               act_in      = ACT_DIRTY_HIT;
            end else begin
               act_in = ACT_READ_CACHED;
            end
         end else if (is_write_ff == REQ_WRITE) begin
            first_in         = (map_rd.dirty == '0);
            count_cluster    = first_in;
            count_write      = 1'b1;
            map_new.dirty    = map_rd.dirty | sub_bit;
            map_new.assigned = map_rd.assigned | sub_bit;
            map_upd          = 1'b1;
            take_slot        = 1'b1;
            slot_in          = next_slot_ff;
            act_in           = ACT_WRITE_ALLOC;
         end else if ((map_rd.assigned & sub_bit) == '0) begin
            map_new.assigned = map_rd.assigned | sub_bit;
            map_upd          = 1'b1;
            take_slot        = 1'b1;
            slot_in          = next_slot_ff;
            act_in           = ACT_READ_FILL;
         end else begin
            slot_in = slot_rd;
            act_in  = ACT_READ_CACHED;
         end
      end
   end

   // Saturating totals.
   always_comb begin
      next_slot_in = next_slot_ff;
      clusters_in  = clusters_ff;
      writes_in    = writes_ff;
      if (take_slot && next_slot_ff != SLOT_MAX) begin
         next_slot_in = next_slot_ff + SLOT_W'(1);
      end
      if (count_cluster && clusters_ff != UCL_MAX) begin
         clusters_in = clusters_ff + UCL_W'(1);
      end
      if (count_write && writes_ff != WCNT_MAX) begin
         writes_in = writes_ff + WCNT_W'(1);
      end
   end

   // Busy and output valid.
   always_comb begin
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers, clearing pass and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         clear_ff     <= 1'b1;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         next_slot_ff <= '0;
         clusters_ff  <= '0;
         writes_ff    <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear_ff) begin
            clr_idx_ff <= clr_idx_ff + CL_W'(1);
            if (clr_idx_ff == '1) begin
               clear_ff <= 1'b0;
            end
         end
         if (done) begin
            next_slot_ff <= next_slot_in;
            clusters_ff  <= clusters_in;
            writes_ff    <= writes_in;
         end
      end
   end

   // Request context capture.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         is_write_ff <= req_type;
         bad_ff      <= req_bad;
         clu_ff      <= req_cluster[CL_W-1:0];
         sub_ff      <= req_sub;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (done) begin
         act_ff   <= act_in;
         slot_ff  <= slot_in;
         first_ff <= first_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_action              = act_ff;
   assign rsp_log_slot            = slot_ff;
   assign rsp_first_cluster_write = first_ff;
   assign rsp_unique_clusters     = clusters_ff;
   assign rsp_write_count         = writes_ff;

   // A new result only appears at the end of a decide cycle.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("result appeared without a request in flight");

   // A rejected request carries no slot and dirties no cluster.
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && act_ff == ACT_BAD) |-> (slot_ff == '0 && !first_ff))
      else $error("bad request result carries a slot or first write");

   // A first cluster write only comes from a write allocation.
   a_first_alloc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && first_ff) |-> (act_ff == ACT_WRITE_ALLOC))
      else $error("first cluster write on a non-allocating result");

   // The slot allocator never moves backward.
   a_slot_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (next_slot_ff >= $past(next_slot_ff)))
      else $error("next log slot decreased");

   // No request enters while the map memory is being cleared.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |=> !busy_ff || $past(busy_ff))
      else $error("request accepted during clearing pass");

endmodule

`default_nettype wire
